### hdl/pcon_pkg.sv
// ----------------------------------------------------------------------------
// pcon_pkg
// Shared types, widths and codes for the position controller.
// ----------------------------------------------------------------------------
package pcon_pkg;

   // field and datapath widths
   localparam int GainW    = 16;
   localparam int LimitW   = 15;
   localparam int PosW     = 16;
   localparam int PeriodW  = 16;
   localparam int ErrW     = 17;
   localparam int DiffW    = 18;
   localparam int IntW     = 48;
   localparam int AccW     = 64;
   localparam int QuoW     = 34;
   localparam int RemW     = 17;
   localparam int DerW     = 35;
   localparam int PeW      = 34;
   localparam int CntW     = 6;
   localparam int DivSteps = 34;
   localparam int MacLast  = 2;
   localparam int CsrIdxW  = 3;
   localparam int ReqDataW = 48;
   localparam int RspDataW = 16;
   localparam int RspUserW = 3;

   // integral saturation bounds
   localparam logic signed [IntW-1:0] IntMax = {1'b0, {(IntW-1){1'b1}}};
   localparam logic signed [IntW-1:0] IntMin = {1'b1, {(IntW-1){1'b0}}};

   // register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_INTEG_GAIN     = 3'd1,
      CSR_DERIV_GAIN     = 3'd2,
      CSR_INV_INTEG_GAIN = 3'd3,
      CSR_OUTPUT_LIMIT   = 3'd4
   } csr_idx_type;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_PLAN,
      ST_EP_MAC,
      ST_EP_ADD,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_DIV_DONE,
      ST_PE_MAC,
      ST_PE_SAVE,
      ST_IN_MAC,
      ST_IN_SHIFT,
      ST_DR_MAC,
      ST_FINISH,
      ST_CHECK,
      ST_AW_MAC,
      ST_AW_ADD,
      ST_OUT
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_PREP,
      OP_MAC,
      OP_INT_ADD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_DONE,
      OP_PE_SAVE,
      OP_IN_SHIFT,
      OP_FINISH,
      OP_OUT
   } op_type;

   // multiplier operand pairs
   typedef enum logic [2:0] {
      MS_ERR_PERIOD,
      MS_PROP_ERR,
      MS_INTEG_ACC,
      MS_DERIV,
      MS_ANTI_WINDUP
   } msel_type;

   typedef struct packed {
      op_type          op;
      msel_type        msel;
      logic [1:0]      chunk;
      logic            clr;
   } cmd_type;

   typedef struct packed {
      logic do_int;
      logic need_div;
      logic sat_aw;
      logic out_free;
   } status_type;

endpackage

### hdl/pcon_dpath.sv
// ----------------------------------------------------------------------------
// pcon_dpath
// Datapath: registers, shared 17x17 multiply-accumulate, serial divider,
// clamp and direction logic, result register.
// ----------------------------------------------------------------------------
module pcon_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pcon_pkg::ReqDataW-1:0]       req_tdata,
   input  logic                                req_tuser,
   input  logic                                csr_valid,
   input  logic [pcon_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [pcon_pkg::GainW-1:0]          csr_data,
   input  logic                                rsp_tready,
   input  pcon_pkg::cmd_type                   cmd,
   output pcon_pkg::status_type                status,
   output logic                                rsp_tvalid,
   output logic [pcon_pkg::RspDataW-1:0]       rsp_tdata,
   output logic [pcon_pkg::RspUserW-1:0]       rsp_tuser
);

   // configuration
   logic signed [pcon_pkg::GainW-1:0]  kp_ff, ki_ff, kd_ff, kinv_ff;
   logic        [pcon_pkg::LimitW-1:0] limit_ff;

   // controller state
   logic signed [pcon_pkg::PosW-1:0]   target_ff;
   logic signed [pcon_pkg::IntW-1:0]   integral_ff, integral_in;
   logic signed [pcon_pkg::ErrW-1:0]   prev_err_ff;
   logic                               dir_ff, clear_pend_ff;
   logic                               rsp_valid_ff;

   // captured item
   logic signed [pcon_pkg::PosW-1:0]    meas_ff, newsp_ff;
   logic        [pcon_pkg::PeriodW-1:0] period_ff;
   logic                                load_ff;

   // working registers
   logic signed [pcon_pkg::ErrW-1:0]  err_ff;
   logic signed [pcon_pkg::DiffW-1:0] diff_ff;
   logic                              do_int_ff, need_div_ff, sat_aw_ff;
   logic signed [pcon_pkg::AccW-1:0]  acc_ff, acc_in;
   logic signed [pcon_pkg::PeW-1:0]   pe_ff, aw_ff;
   logic signed [pcon_pkg::DerW-1:0]  deriv_ff;
   logic        [pcon_pkg::RemW-1:0]  rem_ff, rem_in;
   logic        [pcon_pkg::QuoW-1:0]  quo_ff, quo_in;
   logic        [pcon_pkg::LimitW-1:0] res_mag_ff;
   logic                              res_chg_ff, res_sat_ff;
   logic [pcon_pkg::RspDataW-1:0]     rsp_data_ff;
   logic [pcon_pkg::RspUserW-1:0]     rsp_user_ff;

   // prep logic
   logic signed [pcon_pkg::PosW-1:0]  tgt_new;
   logic signed [pcon_pkg::ErrW-1:0]  err_new, prev_old;
   logic signed [pcon_pkg::DiffW-1:0] diff_new;
   logic                              do_err, do_int_new, do_der_new;

   always_comb begin
      tgt_new    = load_ff ? newsp_ff : target_ff;
      do_err     = !clear_pend_ff;
      do_int_new = !clear_pend_ff && (ki_ff != '0) && !load_ff;
      do_der_new = !clear_pend_ff && (kd_ff != '0);
      err_new    = do_err ? (pcon_pkg::ErrW'(tgt_new) - pcon_pkg::ErrW'(meas_ff)) : '0;
      prev_old   = clear_pend_ff ? '0 : prev_err_ff;
      diff_new   = pcon_pkg::DiffW'(err_new) - pcon_pkg::DiffW'(prev_old);
   end

   // multiplier operand select
   logic signed [pcon_pkg::ErrW-1:0]  mac_a, mac_chunk;
   logic signed [pcon_pkg::IntW-1:0]  mac_b;
   logic signed [2*pcon_pkg::ErrW-1:0] mac_prod;
   logic signed [pcon_pkg::AccW-1:0]  mac_ext, mac_term;

   always_comb begin
      case (cmd.msel)
         pcon_pkg::MS_ERR_PERIOD: begin
            mac_a = err_ff;
            mac_b = pcon_pkg::IntW'(period_ff);
         end
         pcon_pkg::MS_PROP_ERR: begin
            mac_a = pcon_pkg::ErrW'(kp_ff);
            mac_b = pcon_pkg::IntW'(err_ff);
         end
         pcon_pkg::MS_INTEG_ACC: begin
            mac_a = pcon_pkg::ErrW'(ki_ff);
            mac_b = integral_ff;
         end
         pcon_pkg::MS_DERIV: begin
            mac_a = pcon_pkg::ErrW'(kd_ff);
            mac_b = pcon_pkg::IntW'(deriv_ff);
         end
         default: begin
            mac_a = pcon_pkg::ErrW'(kinv_ff);
            mac_b = pcon_pkg::IntW'(aw_ff);
         end
      endcase
   end

   // one 16-bit slice of b per cycle, top slice signed
   always_comb begin
      case (cmd.chunk)
         2'd0:    mac_chunk = {1'b0, mac_b[15:0]};
         2'd1:    mac_chunk = {1'b0, mac_b[31:16]};
         default: mac_chunk = {mac_b[47], mac_b[47:32]};
      endcase
      mac_prod = mac_a * mac_chunk;
      mac_ext  = pcon_pkg::AccW'(mac_prod);
      case (cmd.chunk)
         2'd0:    mac_term = mac_ext;
         2'd1:    mac_term = mac_ext <<< 16;
         default: mac_term = mac_ext <<< 32;
      endcase
   end

   // integral update with saturation
   logic signed [pcon_pkg::AccW-1:0] int_sum;

   always_comb begin
      int_sum = pcon_pkg::AccW'(integral_ff) + acc_ff;
      if (int_sum > pcon_pkg::AccW'(pcon_pkg::IntMax))
         integral_in = pcon_pkg::IntMax;
      else if (int_sum < pcon_pkg::AccW'(pcon_pkg::IntMin))
         integral_in = pcon_pkg::IntMin;
      else
         integral_in = int_sum[pcon_pkg::IntW-1:0];
   end

   // restoring divider step
   logic [pcon_pkg::RemW-1:0]  div_trial;
   logic [pcon_pkg::DiffW-1:0] diff_abs;

   always_comb begin
      diff_abs  = diff_ff[pcon_pkg::DiffW-1] ? pcon_pkg::DiffW'(-diff_ff) : diff_ff;
      div_trial = {rem_ff[pcon_pkg::RemW-2:0], quo_ff[pcon_pkg::QuoW-1]};
      if (div_trial >= {1'b0, period_ff}) begin
         rem_in = div_trial - {1'b0, period_ff};
         quo_in = {quo_ff[pcon_pkg::QuoW-2:0], 1'b1};
      end else begin
         rem_in = div_trial;
         quo_in = {quo_ff[pcon_pkg::QuoW-2:0], 1'b0};
      end
   end

   // clamp, saturation and direction
   logic                             sum_neg, sum_pos, sat, dir_new;
   logic [pcon_pkg::AccW-1:0]        sum_abs;
   logic [pcon_pkg::AccW-9:0]        mag_full;
   logic [pcon_pkg::LimitW-1:0]      mag_out;
   logic signed [pcon_pkg::PeW-1:0]  clamp_q8, aw_new;

   always_comb begin
      sum_neg  = acc_ff[pcon_pkg::AccW-1];
      sum_pos  = !sum_neg && (acc_ff != '0);
      sum_abs  = sum_neg ? pcon_pkg::AccW'(-acc_ff) : acc_ff;
      mag_full = sum_abs[pcon_pkg::AccW-1:8];
      sat      = mag_full > (pcon_pkg::AccW-8)'(limit_ff);
      mag_out  = sat ? limit_ff : mag_full[pcon_pkg::LimitW-1:0];
      clamp_q8 = {11'd0, limit_ff, 8'd0};
      if (!sum_pos)
         clamp_q8 = -clamp_q8;
      aw_new   = clamp_q8 - pe_ff;
      dir_new  = (mag_out != '0) ? sum_pos : dir_ff;
   end

   // accumulator next value
   always_comb begin
      case (cmd.op)
         pcon_pkg::OP_MAC:      acc_in = (cmd.clr ? '0 : acc_ff) + mac_term;
         pcon_pkg::OP_IN_SHIFT: acc_in = pcon_pkg::AccW'(pe_ff) + (acc_ff >>> 16);
         default:               acc_in = acc_ff;
      endcase
   end

   // state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff         <= '0;
         ki_ff         <= '0;
         kd_ff         <= '0;
         kinv_ff       <= '0;
         limit_ff      <= '1;
         target_ff     <= '0;
         integral_ff   <= '0;
         prev_err_ff   <= '0;
         dir_ff        <= 1'b0;
         clear_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (pcon_pkg::csr_idx_type'(csr_index))
               pcon_pkg::CSR_PROP_GAIN:      kp_ff    <= csr_data;
               pcon_pkg::CSR_INTEG_GAIN:     ki_ff    <= csr_data;
               pcon_pkg::CSR_DERIV_GAIN:     kd_ff    <= csr_data;
               pcon_pkg::CSR_INV_INTEG_GAIN: kinv_ff  <= csr_data;
               pcon_pkg::CSR_OUTPUT_LIMIT:   limit_ff <= csr_data[pcon_pkg::LimitW-1:0];
               default: ;
            endcase
         end
         // a new result wins over the handoff of the old one
         if (cmd.op == pcon_pkg::OP_OUT)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready)
            rsp_valid_ff <= 1'b0;
         case (cmd.op)
            pcon_pkg::OP_PREP: begin
               target_ff     <= tgt_new;
               prev_err_ff   <= err_new;
               clear_pend_ff <= 1'b0;
               if (clear_pend_ff)
                  integral_ff <= '0;
            end
            pcon_pkg::OP_INT_ADD: integral_ff <= integral_in;
            pcon_pkg::OP_FINISH: begin
               dir_ff        <= dir_new;
               clear_pend_ff <= dir_new != dir_ff;
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      case (cmd.op)
         pcon_pkg::OP_CAPTURE: begin
            meas_ff   <= req_tdata[15:0];
            period_ff <= req_tdata[31:16];
            newsp_ff  <= req_tdata[47:32];
            load_ff   <= req_tuser;
         end
         pcon_pkg::OP_PREP: begin
            err_ff      <= err_new;
            diff_ff     <= diff_new;
            do_int_ff   <= do_int_new;
            need_div_ff <= do_der_new && (period_ff != '0);
            deriv_ff    <= '0;
         end
         pcon_pkg::OP_DIV_INIT: begin
            rem_ff <= '0;
            quo_ff <= {diff_abs, 16'd0};
         end
         pcon_pkg::OP_DIV_STEP: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
         end
         pcon_pkg::OP_DIV_DONE: begin
            if (diff_ff[pcon_pkg::DiffW-1])
               deriv_ff <= -{1'b0, quo_ff};
            else
               deriv_ff <= {1'b0, quo_ff};
         end
         pcon_pkg::OP_PE_SAVE: pe_ff <= acc_ff[pcon_pkg::PeW-1:0];
         pcon_pkg::OP_FINISH: begin
            res_mag_ff <= mag_out;
            res_sat_ff <= sat;
            res_chg_ff <= dir_new != dir_ff;
            sat_aw_ff  <= sat && do_int_ff;
            aw_ff      <= aw_new;
         end
         pcon_pkg::OP_OUT: begin
            rsp_data_ff <= {1'b0, res_mag_ff};
            rsp_user_ff <= {res_sat_ff, res_chg_ff, dir_ff};
         end
         default: ;
      endcase
   end

   // status and result port
   always_comb begin
      status.do_int   = do_int_ff;
      status.need_div = need_div_ff;
      status.sat_aw   = sat_aw_ff;
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### hdl/pcon_ctrl.sv
// ----------------------------------------------------------------------------
// pcon_ctrl
// Sequencer: steps the datapath through integration, division, the three
// gain products, clamping and the anti-windup correction.
// ----------------------------------------------------------------------------
module pcon_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pcon_pkg::status_type   status,
   output pcon_pkg::cmd_type      cmd
);

   pcon_pkg::state_type          state_ff, state_in;
   logic [pcon_pkg::CntW-1:0]    cnt_ff, cnt_in;
   logic                         mac_last, div_last;

   assign mac_last = cnt_ff == pcon_pkg::CntW'(pcon_pkg::MacLast);
   assign div_last = cnt_ff == pcon_pkg::CntW'(pcon_pkg::DivSteps - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      unique case (state_ff)
         pcon_pkg::ST_IDLE:     if (req_tvalid) state_in = pcon_pkg::ST_PREP;
         pcon_pkg::ST_PREP:     state_in = pcon_pkg::ST_PLAN;
         pcon_pkg::ST_PLAN: begin
            if (status.do_int)        state_in = pcon_pkg::ST_EP_MAC;
            else if (status.need_div) state_in = pcon_pkg::ST_DIV_INIT;
            else                      state_in = pcon_pkg::ST_PE_MAC;
         end
         pcon_pkg::ST_EP_MAC: begin
            if (mac_last) state_in = pcon_pkg::ST_EP_ADD;
            else          cnt_in   = cnt_ff + 1'b1;
         end
         pcon_pkg::ST_EP_ADD: begin
            if (status.need_div) state_in = pcon_pkg::ST_DIV_INIT;
            else                 state_in = pcon_pkg::ST_PE_MAC;
         end
         pcon_pkg::ST_DIV_INIT: state_in = pcon_pkg::ST_DIV_STEP;
         pcon_pkg::ST_DIV_STEP: begin
            if (div_last) state_in = pcon_pkg::ST_DIV_DONE;
            else          cnt_in   = cnt_ff + 1'b1;
         end
         pcon_pkg::ST_DIV_DONE: state_in = pcon_pkg::ST_PE_MAC;
         pcon_pkg::ST_PE_MAC: begin
            if (mac_last) state_in = pcon_pkg::ST_PE_SAVE;
            else          cnt_in   = cnt_ff + 1'b1;
         end
         pcon_pkg::ST_PE_SAVE:  state_in = pcon_pkg::ST_IN_MAC;
         pcon_pkg::ST_IN_MAC: begin
            if (mac_last) state_in = pcon_pkg::ST_IN_SHIFT;
            else          cnt_in   = cnt_ff + 1'b1;
         end
         pcon_pkg::ST_IN_SHIFT: state_in = pcon_pkg::ST_DR_MAC;
         pcon_pkg::ST_DR_MAC: begin
            if (mac_last) state_in = pcon_pkg::ST_FINISH;
            else          cnt_in   = cnt_ff + 1'b1;
         end
         pcon_pkg::ST_FINISH:   state_in = pcon_pkg::ST_CHECK;
         pcon_pkg::ST_CHECK: begin
            if (status.sat_aw) state_in = pcon_pkg::ST_AW_MAC;
            else               state_in = pcon_pkg::ST_OUT;
         end
         pcon_pkg::ST_AW_MAC: begin
            if (mac_last) state_in = pcon_pkg::ST_AW_ADD;
            else          cnt_in   = cnt_ff + 1'b1;
         end
         pcon_pkg::ST_AW_ADD:   state_in = pcon_pkg::ST_OUT;
         pcon_pkg::ST_OUT:      if (status.out_free) state_in = pcon_pkg::ST_IDLE;
         default:               state_in = pcon_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd.op     = pcon_pkg::OP_NONE;
      cmd.msel   = pcon_pkg::MS_ERR_PERIOD;
      cmd.chunk  = cnt_ff[1:0];
      cmd.clr    = cnt_ff == '0;
      unique case (state_ff)
         pcon_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = pcon_pkg::OP_CAPTURE;
         end
         pcon_pkg::ST_PREP:     cmd.op = pcon_pkg::OP_PREP;
         pcon_pkg::ST_EP_MAC:   cmd.op = pcon_pkg::OP_MAC;
         pcon_pkg::ST_EP_ADD:   cmd.op = pcon_pkg::OP_INT_ADD;
         pcon_pkg::ST_DIV_INIT: cmd.op = pcon_pkg::OP_DIV_INIT;
         pcon_pkg::ST_DIV_STEP: cmd.op = pcon_pkg::OP_DIV_STEP;
         pcon_pkg::ST_DIV_DONE: cmd.op = pcon_pkg::OP_DIV_DONE;
         pcon_pkg::ST_PE_MAC: begin
            cmd.op   = pcon_pkg::OP_MAC;
            cmd.msel = pcon_pkg::MS_PROP_ERR;
         end
         pcon_pkg::ST_PE_SAVE:  cmd.op = pcon_pkg::OP_PE_SAVE;
         pcon_pkg::ST_IN_MAC: begin
            cmd.op   = pcon_pkg::OP_MAC;
            cmd.msel = pcon_pkg::MS_INTEG_ACC;
         end
         pcon_pkg::ST_IN_SHIFT: cmd.op = pcon_pkg::OP_IN_SHIFT;
         pcon_pkg::ST_DR_MAC: begin
            // derivative term adds onto the running sum
            cmd.op   = pcon_pkg::OP_MAC;
            cmd.msel = pcon_pkg::MS_DERIV;
            cmd.clr  = 1'b0;
         end
         pcon_pkg::ST_FINISH:   cmd.op = pcon_pkg::OP_FINISH;
         pcon_pkg::ST_AW_MAC: begin
            cmd.op   = pcon_pkg::OP_MAC;
            cmd.msel = pcon_pkg::MS_ANTI_WINDUP;
         end
         pcon_pkg::ST_AW_ADD:   cmd.op = pcon_pkg::OP_INT_ADD;
         pcon_pkg::ST_OUT:      if (status.out_free) cmd.op = pcon_pkg::OP_OUT;
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcon_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // divider count stays in range
   assert property (@(posedge clock) disable iff (reset)
      state_ff == pcon_pkg::ST_DIV_STEP |-> cnt_ff < pcon_pkg::CntW'(pcon_pkg::DivSteps))
      else $error("divider step count out of range");

   // slice index stays within three slices in every product
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcon_pkg::ST_EP_MAC || state_ff == pcon_pkg::ST_PE_MAC ||
       state_ff == pcon_pkg::ST_IN_MAC || state_ff == pcon_pkg::ST_DR_MAC ||
       state_ff == pcon_pkg::ST_AW_MAC) |-> cnt_ff <= pcon_pkg::CntW'(pcon_pkg::MacLast))
      else $error("multiplier slice out of range");

   // anti-windup runs only when integration is on this item
   assert property (@(posedge clock) disable iff (reset)
      state_ff == pcon_pkg::ST_AW_MAC |-> status.do_int)
      else $error("anti-windup without integration");

   // an item starts only from idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == pcon_pkg::ST_PREP |-> $past(state_ff) == pcon_pkg::ST_IDLE)
      else $error("item started outside idle");

endmodule

### hdl/pid_position_controller_top.sv
// ----------------------------------------------------------------------------
// pid_position_controller_top
// Position controller with back-calculation anti-windup: sequencer plus
// datapath around one shared 17x17 multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
// an item takes longer with integration, the derivative divide (34 steps, one
//   quotient bit a cycle) and anti-windup, each run only when needed, and
//   with a stalled output register, which adds its wait
// items: one at a time; the next is taken once the result is in the output
//   register, even while it waits to be taken
// reset: synchronous, clears gains to zero, limit to 32767 and the controller state
module pid_position_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] measured, [31:16] step_period, [47:32] new_setpoint
   input  logic [pcon_pkg::ReqDataW-1:0]       req_tdata,
   // [0] setpoint_load
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [14:0] drive_magnitude, [15] zero
   output logic [pcon_pkg::RspDataW-1:0]       rsp_tdata,
   // [0] drive_direction, [1] direction_changed, [2] saturated
   output logic [pcon_pkg::RspUserW-1:0]       rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcon_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [pcon_pkg::GainW-1:0]          csr_data
);

   pcon_pkg::cmd_type    cmd;
   pcon_pkg::status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   pcon_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcon_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### bench/pid_position_controller_top_test.sv
// ----------------------------------------------------------------------------
// pid_position_controller_top_test
// Self-checking bench for the position controller: a drive predictor in the
// bench models gains, integral, derivative, clamping and direction tracking,
// and every result item is compared against it across several gain settings
// and idle/stall patterns on both streams.
// ----------------------------------------------------------------------------
module pid_position_controller_top_test;

   // expected result of one step
   typedef struct {
      logic [pcon_pkg::LimitW-1:0] magnitude;
      bit                          direction;
      bit                          changed;
      bit                          saturated;
   } drive_result_type;

   // drive predictor and result checker
   class drive_scoreboard;
      longint prop_gain, integ_gain, deriv_gain, inv_integ_gain, output_limit;
      longint target, integral_acc, prev_error;
      bit direction_reg, clear_pending;
      drive_result_type drive_expected[$];
      int errors;

      function new();
         prop_gain = 0;
         integ_gain = 0;
         deriv_gain = 0;
         inv_integ_gain = 0;
         output_limit = 32767;
         target = 0;
         integral_acc = 0;
         prev_error = 0;
         direction_reg = 0;
         clear_pending = 0;
         errors = 0;
      endfunction

      function void write_reg(pcon_pkg::csr_idx_type idx,
                              logic [pcon_pkg::GainW-1:0] value);
         case (idx)
            pcon_pkg::CSR_PROP_GAIN:      prop_gain = longint'($signed(value));
            pcon_pkg::CSR_INTEG_GAIN:     integ_gain = longint'($signed(value));
            pcon_pkg::CSR_DERIV_GAIN:     deriv_gain = longint'($signed(value));
            pcon_pkg::CSR_INV_INTEG_GAIN: inv_integ_gain = longint'($signed(value));
            pcon_pkg::CSR_OUTPUT_LIMIT:
               output_limit = longint'(value[pcon_pkg::LimitW-1:0]);
            default: ;
         endcase
      endfunction

      // clamp to the 48-bit signed integral range
      function longint sat_integral(longint x);
         longint hi;
         hi = 64'h0000_7FFF_FFFF_FFFF;
         if (x > hi) return hi;
         if (x < -hi - 1) return -hi - 1;
         return x;
      endfunction

      function void note_item(logic signed [pcon_pkg::PosW-1:0] measured,
                              logic [pcon_pkg::PeriodW-1:0] period_in, bit load,
                              logic signed [pcon_pkg::PosW-1:0] new_setpoint);
         longint err, deriv, sum, mag, clampv, period;
         bit do_err, do_int, do_der, dir;
         drive_result_type r;
         period = longint'(period_in);
         err = 0;
         deriv = 0;
         r.saturated = 0;
         r.changed = 0;
         if (!clear_pending) begin
            do_err = 1;
            do_int = integ_gain != 0;
            do_der = deriv_gain != 0;
         end else begin
            // clear step after a direction change
            integral_acc = 0;
            prev_error = 0;
            do_err = 0;
            do_int = 0;
            do_der = 0;
            clear_pending = 0;
         end
         if (load) begin
            target = longint'(new_setpoint);
            do_int = 0;
         end
         if (do_err) err = target - longint'(measured);
         if (do_int) integral_acc = sat_integral(integral_acc + err * period);
         if (do_der && period != 0) deriv = ((err - prev_error) * 65536) / period;
         prev_error = err;
         sum = prop_gain * err + ((integ_gain * integral_acc) >>> 16) + deriv_gain * deriv;
         mag = (sum < 0) ? ((-sum) >>> 8) : (sum >>> 8);
         if (mag > output_limit) begin
            r.saturated = 1;
            clampv = (sum > 0) ? output_limit : -output_limit;
            mag = output_limit;
            if (do_int)
               integral_acc = sat_integral(integral_acc +
                  inv_integ_gain * (clampv * 256 - prop_gain * err));
         end
         dir = direction_reg;
         if (mag != 0) dir = sum > 0;
         if (dir != direction_reg) begin
            direction_reg = dir;
            r.changed = 1;
            clear_pending = 1;
         end
         r.magnitude = mag[pcon_pkg::LimitW-1:0];
         r.direction = direction_reg;
         drive_expected.push_back(r);
      endfunction

      function void check_result(logic [pcon_pkg::RspDataW-1:0] data,
                                 logic [pcon_pkg::RspUserW-1:0] user);
         drive_result_type r;
         if (drive_expected.size() == 0) begin
            $error("result item with no expected item waiting");
            errors++;
            return;
         end
         r = drive_expected.pop_front();
         if (data[pcon_pkg::LimitW-1:0] !== r.magnitude) begin
            $error("drive_magnitude: expected %0d, got %0d", r.magnitude,
                   data[pcon_pkg::LimitW-1:0]);
            errors++;
         end
         if (user[0] !== r.direction) begin
            $error("drive_direction: expected %0d, got %0d", r.direction, user[0]);
            errors++;
         end
         if (user[1] !== r.changed) begin
            $error("direction_changed: expected %0d, got %0d", r.changed, user[1]);
            errors++;
         end
         if (user[2] !== r.saturated) begin
            $error("saturated: expected %0d, got %0d", r.saturated, user[2]);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [pcon_pkg::ReqDataW-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [pcon_pkg::RspDataW-1:0] rsp_tdata;
   logic [pcon_pkg::RspUserW-1:0] rsp_tuser;
   logic csr_valid, csr_ready;
   logic [pcon_pkg::CsrIdxW-1:0] csr_index;
   logic [pcon_pkg::GainW-1:0] csr_data;

   drive_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;

   pid_position_controller_top dut (.*);

   // clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   // receiver backpressure
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // check results before noting the item taken on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready)
            sb.note_item(req_tdata[15:0], req_tdata[31:16], req_tuser, req_tdata[47:32]);
      end
   end

   task automatic write_csr(pcon_pkg::csr_idx_type idx, logic [pcon_pkg::GainW-1:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                            logic [15:0] inv, logic [15:0] lim);
      write_csr(pcon_pkg::CSR_PROP_GAIN, kp);
      write_csr(pcon_pkg::CSR_INTEG_GAIN, ki);
      write_csr(pcon_pkg::CSR_DERIV_GAIN, kd);
      write_csr(pcon_pkg::CSR_INV_INTEG_GAIN, inv);
      write_csr(pcon_pkg::CSR_OUTPUT_LIMIT, lim);
   endtask

   task automatic send_item(logic [15:0] measured, logic [15:0] period, bit load,
                            logic [15:0] new_setpoint);
      if ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_tvalid <= 0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1;
      req_tdata <= {new_setpoint, period, measured};
      req_tuser <= load;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending, wait for every expected result, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (sb.drive_expected.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // mostly tracking-style samples near the target, some full-range noise
   task automatic send_random(int count);
      logic [15:0] m, p, sp;
      bit ld;
      repeat (count) begin
         ld = ($urandom_range(9) == 0);
         sp = 16'($urandom);
         if ($urandom_range(3) == 0) m = 16'($urandom);
         else m = 16'(sb.target) + 16'($signed($urandom_range(400)) - 200);
         case ($urandom_range(3))
            0: p = 16'($urandom);
            1: p = 16'($urandom_range(64, 1));
            default: p = 16'($urandom_range(4096, 1));
         endcase
         send_item(m, p, ld, sp);
      end
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = 0;
      csr_valid = 0;
      csr_index = pcon_pkg::CSR_PROP_GAIN;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset gains: output stays zero
      send_item(16'h1234, 16'd100, 0, 16'h0);
      send_item(16'h8000, 16'hFFFF, 1, 16'h7FFF);
      drain();

      // moderate gains, directed corners
      set_gains(16'd256, 16'd64, 16'd16, 16'd1024, 16'd1000);
      send_item(16'h0000, 16'd1, 1, 16'h7FFF);
      send_item(16'h8000, 16'hFFFF, 0, 16'h0);
      send_item(16'h7FFF, 16'd1, 0, 16'h0);
      send_item(16'h7FFF, 16'd0, 0, 16'h0);       // zero period
      send_item(16'h0000, 16'd1000, 1, 16'h8000);
      send_item(16'h8000, 16'd1000, 0, 16'h0);
      send_item(16'h8000, 16'd1000, 0, 16'h0);    // equal target: zero output
      send_item(16'h0010, 16'd500, 1, 16'h0020);
      send_item(16'h0030, 16'd500, 0, 16'h0);     // clear step
      send_item(16'h0030, 16'd500, 0, 16'h0);     // direction flip
      send_item(16'hFFFF, 16'd2, 1, 16'hFFFF);
      send_item(16'h5555, 16'hAAAA, 0, 16'hAAAA);
      send_item(16'hAAAA, 16'h5555, 1, 16'h5555);
      send_random(90);
      drain();

      // largest positive gains, sender idling
      idle_pct = 49;
      set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_random(40);
      send_item(16'h8000, 16'd1, 1, 16'h7FFF);
      repeat (12) send_item(16'h8000, 16'd65535, 0, 16'h0);  // drive integral to saturate
      send_random(40);
      drain();

      // most negative gains, zero limit, receiver stalling
      idle_pct = 0;
      stall_pct = 49;
      set_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
      send_random(90);
      drain();

      // random gains, both sides idling
      idle_pct = 32;
      stall_pct = 32;
      set_gains(16'($urandom_range(2000) - 1000), 16'($urandom_range(400) - 200),
                16'($urandom_range(200) - 100), 16'($urandom_range(8000) - 4000),
                16'($urandom_range(32767)));
      send_random(170);
      drain();

      // no integration, pause midway until all results are in
      idle_pct = 0;
      stall_pct = 0;
      set_gains(16'($urandom), 16'd0, 16'($urandom), 16'($urandom), 16'd200);
      send_random(45);
      drain();
      send_random(45);
      drain();

      if (sb.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
